/* hw/rtl/sdhe_pkg.sv */
// shared constants, types and event codes for the switch debounce block
package sdhe_pkg;

    localparam int NUM_SWITCHES = 4;
    localparam int PINS_W       = 4;
    localparam int EV_W         = 3;
    localparam int EVENTS_W     = 12;
    localparam int CNT_W        = 8;
    localparam int CFG_DATA_W   = 8;
    localparam int CFG_INDEX_W  = 2;

    typedef logic [EV_W-1:0]  ev_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam ev_t EV_NONE      = 3'd0;
    localparam ev_t EV_PRESS     = 3'd1;
    localparam ev_t EV_SHORT_REL = 3'd2;
    localparam ev_t EV_LONG_REL  = 3'd3;
    localparam ev_t EV_HOLD      = 3'd4;
    localparam ev_t EV_REPEAT    = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS        = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_REPEAT_TICKS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESSED_LEVEL     = 2'd3;

    localparam cnt_t RST_DEBOUNCE_TICKS    = 8'd8;
    localparam cnt_t RST_HOLD_TICKS        = 8'd100;
    localparam cnt_t RST_HOLD_REPEAT_TICKS = 8'd150;
    localparam logic RST_PRESSED_LEVEL     = 1'b0;

    typedef struct packed {
        cnt_t debounce_ticks;
        cnt_t hold_ticks;
        cnt_t hold_repeat_ticks;
        logic pressed_level;
    } cfg_t;

    typedef ev_t [NUM_SWITCHES-1:0] ev_vec_t;

endpackage

/* hw/rtl/sdhe_lane.sv */
// one switch lane: debounce counter, debounced level and hold counter
module sdhe_lane (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          raw,
    input  sdhe_pkg::cfg_t cfg,
    output sdhe_pkg::ev_t ev
);

    logic          level_reg, level_next;
    sdhe_pkg::cnt_t dcount_reg, dcount_next;
    sdhe_pkg::cnt_t hcount_reg, hcount_next;
    sdhe_pkg::cnt_t dcount_inc;
    sdhe_pkg::cnt_t hcount_inc;
    logic          was_pressed;
    logic          is_pressed;

    assign dcount_inc = dcount_reg + 1'b1;
    assign hcount_inc = hcount_reg + 1'b1;

    always_comb
    begin
        level_next  = level_reg;
        dcount_next = '0;
        if (raw != level_reg)
        begin
            if (dcount_inc == cfg.debounce_ticks)
            begin
                level_next = raw;
            end
            else
            begin
                dcount_next = dcount_inc;
            end
        end
    end

    assign was_pressed = (level_reg == cfg.pressed_level);
    assign is_pressed  = (level_next == cfg.pressed_level);

    always_comb
    begin
        hcount_next = hcount_reg;
        ev          = sdhe_pkg::EV_NONE;
        priority if (is_pressed && !was_pressed)
        begin
            hcount_next = '0;
            ev          = sdhe_pkg::EV_PRESS;
        end
        else if (!is_pressed && was_pressed)
        begin
            ev = (hcount_reg < cfg.hold_ticks) ? sdhe_pkg::EV_SHORT_REL
                                               : sdhe_pkg::EV_LONG_REL;
        end
        else if (is_pressed && was_pressed && (hcount_reg < cfg.hold_repeat_ticks))
        begin
            hcount_next = hcount_inc;
            if (hcount_inc == cfg.hold_ticks)
            begin
                ev = sdhe_pkg::EV_HOLD;
            end
            // repeat wins and reloads the count back to the hold point
            if (hcount_inc == cfg.hold_repeat_ticks)
            begin
                ev          = sdhe_pkg::EV_REPEAT;
                hcount_next = cfg.hold_ticks;
            end
        end
        else
        begin
            ev = sdhe_pkg::EV_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= ~sdhe_pkg::RST_PRESSED_LEVEL;
            dcount_reg <= '0;
            hcount_reg <= '0;
        end
        else if (step)
        begin
            level_reg  <= level_next;
            dcount_reg <= dcount_next;
            hcount_reg <= hcount_next;
        end
    end

endmodule

/* hw/rtl/sdhe_merge.sv */
// packs the lane event codes into one word and holds it in the output register
module sdhe_merge (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  sdhe_pkg::ev_vec_t ev,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [sdhe_pkg::EVENTS_W-1:0] switch_events
);

    logic                          valid_reg, valid_next;
    logic [sdhe_pkg::EVENTS_W-1:0] word_reg;
    logic [sdhe_pkg::EVENTS_W-1:0] word_next;

    // lanes whose code does not fit the output word are dropped
    always_comb
    begin
        word_next = '0;
        for (int i = 0; i < sdhe_pkg::NUM_SWITCHES; i++)
        begin
            if ((i + 1) * sdhe_pkg::EV_W <= sdhe_pkg::EVENTS_W)
            begin
                word_next[i*sdhe_pkg::EV_W +: sdhe_pkg::EV_W] = ev[i];
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        priority if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid     = valid_reg;
    assign switch_events = word_reg;

endmodule

/* hw/rtl/switch_debounce_hold_events_core.sv */
// top level of the switch debounce block with press, release, hold and repeat events
//
// usage
//   input channel: in_valid / in_stall with pin_levels, one word per sampling tick,
//   bit i is the raw level of switch i
//   output channel: out_valid / out_stall with switch_events, three bits per switch
//   config: cfg_write with cfg_index and cfg_data, written only while idle;
//   0 debounce_ticks, 1 hold_ticks, 2 hold_repeat_ticks, 3 pressed_level
//   one lane per switch updates its counters at the accept edge; the merge
//   stage packs the lane codes into the output register
//   result: registered, valid in the cycle after its input word is taken
//   throughput: one word per cycle while out_stall holds no output word, set
//   by the single output register, which is refilled in the same cycle it is taken
//   stall: while the output word waits under out_stall, in_stall is raised and
//   the lanes hold their state; nothing is lost
//   reset: counters cleared, every switch at the released level, registers at
//   debounce 8, hold 100, repeat 150, pressed level 0, no output word pending
module switch_debounce_hold_events_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [sdhe_pkg::PINS_W-1:0]      pin_levels,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [sdhe_pkg::EVENTS_W-1:0]    switch_events,
    input  logic                             cfg_write,
    input  logic [sdhe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sdhe_pkg::CFG_DATA_W-1:0]  cfg_data
);

    sdhe_pkg::cfg_t    cfg_reg;
    sdhe_pkg::ev_vec_t lane_ev;
    logic              accept;

    assign in_stall = out_valid && out_stall;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks    <= sdhe_pkg::RST_DEBOUNCE_TICKS;
            cfg_reg.hold_ticks        <= sdhe_pkg::RST_HOLD_TICKS;
            cfg_reg.hold_repeat_ticks <= sdhe_pkg::RST_HOLD_REPEAT_TICKS;
            cfg_reg.pressed_level     <= sdhe_pkg::RST_PRESSED_LEVEL;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sdhe_pkg::REG_DEBOUNCE_TICKS:    cfg_reg.debounce_ticks    <= cfg_data;
                sdhe_pkg::REG_HOLD_TICKS:        cfg_reg.hold_ticks        <= cfg_data;
                sdhe_pkg::REG_HOLD_REPEAT_TICKS: cfg_reg.hold_repeat_ticks <= cfg_data;
                sdhe_pkg::REG_PRESSED_LEVEL:     cfg_reg.pressed_level     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    for (genvar i = 0; i < sdhe_pkg::NUM_SWITCHES; i++)
    begin : g_lane
        logic raw;

        // switches beyond the pin word read level 0
        if (i < sdhe_pkg::PINS_W)
        begin : g_pin
            assign raw = pin_levels[i];
        end
        else
        begin : g_nopin
            assign raw = 1'b0;
        end

        sdhe_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (accept),
            .raw   (raw),
            .cfg   (cfg_reg),
            .ev    (lane_ev[i])
        );
    end

    sdhe_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .ev            (lane_ev),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .switch_events (switch_events)
    );

    a_taken_word_appears: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted word produced no output word");

    a_drained_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !accept) |=> !out_valid)
        else $error("output word repeated after it was taken");

    a_no_accept_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !accept)
        else $error("input taken while output word is held");

endmodule

/* sim/tb.sv */
// self-checking testbench for the switch debounce, hold and repeat event core
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [sdhe_pkg::PINS_W-1:0]     pins_t;
    typedef logic [sdhe_pkg::EVENTS_W-1:0]   events_t;
    typedef logic [sdhe_pkg::CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [sdhe_pkg::CFG_DATA_W-1:0] cfg_data_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    pins_t      pin_levels = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    events_t    switch_events;
    logic       cfg_write = 1'b0;
    cfg_index_t cfg_index = '0;
    cfg_data_t  cfg_data = '0;

    switch_debounce_hold_events_core uut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state, one lane per switch
    sdhe_pkg::cfg_t model_cfg;
    logic           lane_level [sdhe_pkg::NUM_SWITCHES];
    sdhe_pkg::cnt_t lane_bounce [sdhe_pkg::NUM_SWITCHES];
    sdhe_pkg::cnt_t lane_hold [sdhe_pkg::NUM_SWITCHES];

    events_t events_due [$];
    int errors = 0;
    int words_taken = 0;
    int words_checked = 0;
    int code_tally [8];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;

    function automatic void reset_model();
        model_cfg = '{sdhe_pkg::RST_DEBOUNCE_TICKS, sdhe_pkg::RST_HOLD_TICKS,
                      sdhe_pkg::RST_HOLD_REPEAT_TICKS, sdhe_pkg::RST_PRESSED_LEVEL};
        for (int i = 0; i < sdhe_pkg::NUM_SWITCHES; i++)
        begin
            lane_level[i] = ~sdhe_pkg::RST_PRESSED_LEVEL;
            lane_bounce[i] = '0;
            lane_hold[i] = '0;
        end
    endfunction

    function automatic void apply_reg(input cfg_index_t idx, input cfg_data_t data);
        case (idx)
            sdhe_pkg::REG_DEBOUNCE_TICKS:    model_cfg.debounce_ticks = data;
            sdhe_pkg::REG_HOLD_TICKS:        model_cfg.hold_ticks = data;
            sdhe_pkg::REG_HOLD_REPEAT_TICKS: model_cfg.hold_repeat_ticks = data;
            sdhe_pkg::REG_PRESSED_LEVEL:     model_cfg.pressed_level = data[0];
            default: ;
        endcase
    endfunction

    function automatic events_t predict_events(input pins_t pins);
        events_t word;
        logic raw;
        logic now_lvl;
        logic was_pr;
        logic is_pr;
        sdhe_pkg::ev_t code;
        word = '0;
        for (int i = 0; i < sdhe_pkg::NUM_SWITCHES; i++)
        begin
            raw = (i < sdhe_pkg::PINS_W) ? pins[i] : 1'b0;
            now_lvl = lane_level[i];
            code = sdhe_pkg::EV_NONE;
            if (raw != lane_level[i])
            begin
                // counter wraps, so a zero setting needs 256 samples
                lane_bounce[i] = lane_bounce[i] + sdhe_pkg::cnt_t'(1);
                if (lane_bounce[i] == model_cfg.debounce_ticks)
                begin
                    now_lvl = raw;
                    lane_bounce[i] = '0;
                end
            end
            else
                lane_bounce[i] = '0;
            was_pr = (lane_level[i] == model_cfg.pressed_level);
            is_pr = (now_lvl == model_cfg.pressed_level);
            if (is_pr && !was_pr)
            begin
                lane_hold[i] = '0;
                code = sdhe_pkg::EV_PRESS;
            end
            else if (!is_pr && was_pr)
                code = (lane_hold[i] < model_cfg.hold_ticks) ? sdhe_pkg::EV_SHORT_REL
                                                             : sdhe_pkg::EV_LONG_REL;
            else if (is_pr && lane_hold[i] < model_cfg.hold_repeat_ticks)
            begin
                lane_hold[i] = lane_hold[i] + sdhe_pkg::cnt_t'(1);
                if (lane_hold[i] == model_cfg.hold_ticks)
                    code = sdhe_pkg::EV_HOLD;
                if (lane_hold[i] == model_cfg.hold_repeat_ticks)
                begin
                    code = sdhe_pkg::EV_REPEAT;
                    lane_hold[i] = model_cfg.hold_ticks;
                end
            end
            lane_level[i] = now_lvl;
            if (sdhe_pkg::EV_W*i + sdhe_pkg::EV_W <= sdhe_pkg::EVENTS_W)
                word[sdhe_pkg::EV_W*i +: sdhe_pkg::EV_W] = code;
        end
        return word;
    endfunction

    // predictor and checker, both sampling at the accept edge
    always @(posedge clk)
    begin
        events_t want;
        if (!rst_n)
        begin
            reset_model();
            events_due.delete();
        end
        else
        begin
            if (cfg_write)
                apply_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
            begin
                events_due.push_back(predict_events(pin_levels));
                words_taken++;
            end
            if (out_valid && !out_stall)
            begin
                if (events_due.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, switch_events);
                    errors++;
                end
                else
                begin
                    want = events_due.pop_front();
                    words_checked++;
                    if (switch_events !== want)
                    begin
                        $display("%0t: switch_events mismatch, expected %h, got %h",
                                 $time, want, switch_events);
                        errors++;
                    end
                    for (int i = 0; i < sdhe_pkg::NUM_SWITCHES; i++)
                        code_tally[want[sdhe_pkg::EV_W*i +: sdhe_pkg::EV_W]]++;
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        #20_000_000;
        $display("[switch_debounce_hold_events_core] ERROR");
        $finish;
    end

    task automatic send_word(input pins_t pins);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pin_levels <= pins;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    // the extra edge lets the checker log the last word taken before looking
    task automatic wait_drained();
        @(posedge clk);
        while (events_due.size() != 0 || out_valid)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_config(input sdhe_pkg::cnt_t db, input sdhe_pkg::cnt_t hd,
                              input sdhe_pkg::cnt_t rp, input logic lvl);
        cfg_data_t lvl_word;
        lvl_word = cfg_data_t'($urandom);
        lvl_word[0] = lvl;
        stop_sending();
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= sdhe_pkg::REG_DEBOUNCE_TICKS;
        cfg_data <= db;
        @(posedge clk);
        cfg_index <= sdhe_pkg::REG_HOLD_TICKS;
        cfg_data <= hd;
        @(posedge clk);
        cfg_index <= sdhe_pkg::REG_HOLD_REPEAT_TICKS;
        cfg_data <= rp;
        @(posedge clk);
        cfg_index <= sdhe_pkg::REG_PRESSED_LEVEL;
        cfg_data <= lvl_word;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // runs of steady pin patterns with glitches, plus some pure noise runs
    task automatic send_runs(input int n_words, input int max_run);
        pins_t target;
        int run_len;
        int sent;
        bit noisy;
        target = pins_t'($urandom);
        sent = 0;
        while (sent < n_words)
        begin
            target = target ^ pins_t'($urandom);
            run_len = $urandom_range(max_run, 1);
            noisy = ($urandom_range(99) < 10);
            for (int k = 0; k < run_len && sent < n_words; k++)
            begin
                if (noisy)
                    send_word(pins_t'($urandom));
                else if ($urandom_range(99) < 6)
                    send_word(target ^ (pins_t'(1) << $urandom_range(sdhe_pkg::PINS_W-1)));
                else
                    send_word(target);
                sent++;
            end
        end
    endtask

    task automatic check_reset_values();
        // default debounce of 8 presses switch 0 on the eighth low sample
        send_word(4'hF);
        repeat (8) send_word(4'hE);
    endtask

    task automatic check_directed_events();
        set_config(8'd2, 8'd2, 8'd3, 1'b0);
        send_word(4'h0);
        send_word(4'h0);
        repeat (4) send_word(4'h0);
        send_word(4'hF);
        send_word(4'h0);
        send_word(4'hF);
        send_word(4'hF);
        send_word(4'h6);
        send_word(4'h6);
        send_word(4'hF);
        send_word(4'hF);
        // pressed level flips: released lanes now read as pressed, with no press event
        set_config(8'd1, 8'd3, 8'd3, 1'b1);
        repeat (4) send_word(4'hF);
        send_word(4'h0);
    endtask

    task automatic check_random_settings();
        int db [5] = '{1, 3, 2, 4, 1};
        int hd [5] = '{1, 6, 5, 8, 0};
        int rp [5] = '{2, 9, 5, 3, 4};
        int pl [5] = '{0, 1, 0, 1, 1};
        int s_pct [3] = '{25, 66, 0};
        int r_pct [3] = '{66, 25, 0};
        for (int m = 0; m < 3; m++)
        begin
            send_idle_pct = s_pct[m];
            recv_stall_pct = r_pct[m];
            for (int c = 0; c < 5; c++)
            begin
                set_config(sdhe_pkg::cnt_t'(db[c]), sdhe_pkg::cnt_t'(hd[c]),
                           sdhe_pkg::cnt_t'(rp[c]), pl[c][0]);
                send_runs(20, 2 * db[c] + rp[c] + 4);
            end
        end
    endtask

    task automatic check_zero_debounce();
        set_config(8'd0, 8'd1, 8'd2, 1'b0);
        repeat (257) send_word(4'hA);
        repeat (40) send_word(4'h5);
        send_word(4'hA);
        repeat (257) send_word(4'h5);
    endtask

    task automatic check_extreme_counts();
        // widest hold settings: hold count climbs to 255, then repeats every sample
        set_config(8'd1, 8'd254, 8'd255, 1'b1);
        repeat (2) send_word(4'h0);
        repeat (260) send_word(4'hF);
        repeat (2) send_word(4'h3);
    endtask

    task automatic check_output_hold_off();
        set_config(8'd2, 8'd4, 8'd6, 1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 200;
        send_runs(60, 12);
    endtask

    task automatic check_drain_pause();
        send_idle_pct = 25;
        recv_stall_pct = 25;
        send_runs(20, 12);
        stop_sending();
        wait_drained();
        send_runs(20, 12);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 25;
        recv_stall_pct = 66;
        check_reset_values();
        check_directed_events();
        check_random_settings();
        check_zero_debounce();
        check_extreme_counts();
        check_output_hold_off();
        check_drain_pause();
        stop_sending();
        wait_drained();
        repeat (4) @(posedge clk);
        $display("sampling words taken %0d, result words checked %0d, mismatches %0d",
                 words_taken, words_checked, errors);
        $display("lane events: press %0d, short rel %0d, long rel %0d, hold %0d, repeat %0d",
                 code_tally[sdhe_pkg::EV_PRESS], code_tally[sdhe_pkg::EV_SHORT_REL],
                 code_tally[sdhe_pkg::EV_LONG_REL], code_tally[sdhe_pkg::EV_HOLD],
                 code_tally[sdhe_pkg::EV_REPEAT]);
        if (errors == 0 && events_due.size() == 0)
            $display("[switch_debounce_hold_events_core] OK");
        else
            $display("[switch_debounce_hold_events_core] ERROR");
        $finish;
    end

endmodule
